FILE: sv/grid_dda_ray_caster_top_macros.svh
// Assertion helpers for the ray caster.
`ifndef GRID_DDA_RAY_CASTER_TOP_MACROS_SVH
`define GRID_DDA_RAY_CASTER_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication under reset
`define GDDRC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication under reset
`define GDDRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GDDRC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define GDDRC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/gddrc_pkg.sv
package gddrc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAP_BITS  = 6;
  localparam int MAP_SIZE  = 1 << MAP_BITS;
  localparam int MAP_CELLS = MAP_SIZE * MAP_SIZE;
  localparam int CELL_AW   = 2 * MAP_BITS;
  localparam int LOOP_MAX  = 2 * MAP_SIZE + 2;

  // shared divider operand widths
  localparam int DIV_NW = 40;
  localparam int DIV_DW = 34;

  localparam logic [21:0] DIST_MAX  = 22'h3FFFFF;
  localparam logic [36:0] DELTA_CAP = 37'h10_0000_0000;

  // function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CAST  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_HIT   = 2'd0;
  localparam logic [1:0] ST_EDGE  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_PLAYER_X    = 3'd0;
  localparam logic [2:0] CFG_PLAYER_Y    = 3'd1;
  localparam logic [2:0] CFG_VIEW_DIR_X  = 3'd2;
  localparam logic [2:0] CFG_VIEW_DIR_Y  = 3'd3;
  localparam logic [2:0] CFG_CAM_PLANE_X = 3'd4;
  localparam logic [2:0] CFG_CAM_PLANE_Y = 3'd5;
  localparam logic [2:0] CFG_SCREEN_W    = 3'd6;

  typedef struct packed {
    logic               func;
    logic [11:0]        column;
    logic [5:0]         cell_x;
    logic [5:0]         cell_y;
    logic               cell_wall;
  } item_t;

  typedef struct packed {
    logic [21:0]        player_x;
    logic [21:0]        player_y;
    logic signed [17:0] view_dir_x;
    logic signed [17:0] view_dir_y;
    logic signed [17:0] cam_plane_x;
    logic signed [17:0] cam_plane_y;
    logic [12:0]        screen_width;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

endpackage

FILE: sv/grid_dda_ray_caster_top.sv
// Grid ray caster. A word with func 0 writes one map cell and returns status 2, set in
// the S_WRITE state; a word with func 1 casts the ray for one screen column and
// returns distance, side and cell. A cast steps through at most 130 grid cells; its
// time is set by the shared serial divider, used up to four times per cast, the
// shift-and-add for the side distances and the map read in each step. Two words may
// queue behind the one in work. After reset all 4096 map cells are cleared, one cell
// per cycle; busy stays high during that pass. Each result appears for a single cycle
// with result_valid_o and cannot be stalled by the receiver. Configuration may be
// written only while no word is in flight.
module grid_dda_ray_caster_top import gddrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [11:0] column_i,
  input  logic [5:0]  cell_x_i,
  input  logic [5:0]  cell_y_i,
  input  logic        cell_wall_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [21:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [21:0] perp_dist_o,
  output logic        hit_side_o,
  output logic [5:0]  hit_x_o,
  output logic [5:0]  hit_y_o,
  output logic [1:0]  status_o
);

  logic     clearing, pop, item_valid;
  item_t    item;
  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // accept and queue words, hold configuration
  gddrc_front u_front (
    .clk_i, .rst_ni, .start, .busy,
    .func_i, .column_i, .cell_x_i, .cell_y_i, .cell_wall_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .clearing_i   (clearing),
    .pop_i        (pop),
    .item_valid_o (item_valid),
    .item_o       (item),
    .cfg_o        (cfg)
  );

  // shared serial divider
  gddrc_div u_div (
    .clk_i, .rst_ni,
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // map, ray set-up and cell stepping
  gddrc_back u_back (
    .clk_i, .rst_ni,
    .item_valid_i (item_valid),
    .item_i       (item),
    .cfg_i        (cfg),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .result_valid_o, .perp_dist_o, .hit_side_o, .hit_x_o, .hit_y_o, .status_o
  );

endmodule

FILE: sv/gddrc_front.sv
module gddrc_front import gddrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [11:0] column_i,
  input  logic [5:0]  cell_x_i,
  input  logic [5:0]  cell_y_i,
  input  logic        cell_wall_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [21:0] cfg_data_i,
  input  logic        clearing_i,
  input  logic        pop_i,
  output logic        item_valid_o,
  output item_t       item_o,
  output cfg_t        cfg_o
);

  item_t      fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push;
  cfg_t       cfg_q;

  // hold off new words while the queue is full or the map is being cleared
  assign busy = (count_q == 2'd2) || clearing_i;
  assign push = start && !busy;

  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = fifo_q[rd_ptr_q];
  assign cfg_o        = cfg_q;

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      if (push && !pop_i) count_q <= count_q + 2'd1;
      else if (!push && pop_i) count_q <= count_q - 2'd1;
    end
  end

  // queue payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{func: func_i, column: column_i, cell_x: cell_x_i,
                             cell_y: cell_y_i, cell_wall: cell_wall_i};
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.player_x     <= 22'd0;
      cfg_q.player_y     <= 22'd0;
      cfg_q.view_dir_x   <= 18'sd65536;
      cfg_q.view_dir_y   <= 18'sd0;
      cfg_q.cam_plane_x  <= 18'sd0;
      cfg_q.cam_plane_y  <= 18'sd43253;
      cfg_q.screen_width <= 13'd640;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PLAYER_X:    cfg_q.player_x     <= cfg_data_i;
        CFG_PLAYER_Y:    cfg_q.player_y     <= cfg_data_i;
        CFG_VIEW_DIR_X:  cfg_q.view_dir_x   <= signed'(cfg_data_i[17:0]);
        CFG_VIEW_DIR_Y:  cfg_q.view_dir_y   <= signed'(cfg_data_i[17:0]);
        CFG_CAM_PLANE_X: cfg_q.cam_plane_x  <= signed'(cfg_data_i[17:0]);
        CFG_CAM_PLANE_Y: cfg_q.cam_plane_y  <= signed'(cfg_data_i[17:0]);
        CFG_SCREEN_W:    cfg_q.screen_width <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/gddrc_div.sv
module gddrc_div import gddrc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, done_q;
  logic [5:0]        cnt_q;
  logic [DIV_DW-1:0] rem_q, den_q;
  logic [DIV_NW-1:0] quo_q;
  logic [DIV_DW:0]   trial;
  logic              fits;

  // one restoring step per cycle
  assign trial = {rem_q, quo_q[DIV_NW-1]};
  assign fits  = trial >= {1'b0, den_q};

  assign rsp_o = '{busy: busy_q, done: done_q, quot: quo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(DIV_NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= fits ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
      quo_q <= {quo_q[DIV_NW-2:0], fits};
    end
  end

endmodule

FILE: sv/gddrc_back.sv
module gddrc_back import gddrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  item_t       item_i,
  input  cfg_t        cfg_i,
  output logic        pop_o,
  output logic        clearing_o,
  output div_req_t    div_req_o,
  input  div_rsp_t    div_rsp_i,
  output logic        result_valid_o,
  output logic [21:0] perp_dist_o,
  output logic        hit_side_o,
  output logic [5:0]  hit_x_o,
  output logic [5:0]  hit_y_o,
  output logic [1:0]  status_o
);

  `include "grid_dda_ray_caster_top_macros.svh"

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_WRITE, S_CAM, S_CAM_W, S_RAY_X, S_RAY_Y,
    S_DX, S_DX_W, S_DY, S_DY_W, S_SINIT, S_SIDE, S_STEP, S_CHK, S_TEST,
    S_PERP, S_PERP_W
  } state_e;

  state_e               state_q;
  item_t                item_q;
  logic [CELL_AW-1:0]   clr_q;
  logic signed [30:0]   cam_q;
  logic signed [33:0]   rx_q, ry_q;
  logic [36:0]          dx_q, dy_q;
  logic [44:0]          sx_q, sy_q;
  logic signed [7:0]    mx_q, my_q;
  logic                 side_q;
  logic [7:0]           cnt_q;
  logic [4:0]           mcnt_q;
  logic [53:0]          accx_q, accy_q, mcx_q, mcy_q;
  logic [16:0]          mbx_q, mby_q;
  logic                 valid_q, side_o_q;
  logic [21:0]          perp_q;
  logic [5:0]           hx_q, hy_q;
  logic [1:0]           status_q;
  logic                 map_mem [MAP_CELLS];
  logic                 rd_q;

  logic                 mem_we, mem_wdata;
  logic [CELL_AW-1:0]   mem_waddr;
  logic [12:0]          width;
  logic signed [48:0]   prod_ray;
  logic [16:0]          fracx, fracy;
  logic [53:0]          accx_d, accy_d;
  logic signed [23:0]   num;
  logic signed [33:0]   r_sel;
  logic [23:0]          num_abs;
  logic [33:0]          r_abs;
  logic                 out_x, out_y;

  assign clearing_o = (state_q == S_CLEAR);
  assign pop_o      = (state_q == S_IDLE) && item_valid_i;
  assign width      = (cfg_i.screen_width == 13'd0) ? 13'd1 : cfg_i.screen_width;

  // camera plane product for the component in work
  assign prod_ray = (state_q == S_RAY_X) ? cfg_i.cam_plane_x * cam_q
                                         : cfg_i.cam_plane_y * cam_q;

  // distance from the player to the first grid line on each axis
  assign fracx = rx_q[33] ? {1'b0, cfg_i.player_x[FRAC_BITS-1:0]}
                          : 17'd65536 - {1'b0, cfg_i.player_x[FRAC_BITS-1:0]};
  assign fracy = ry_q[33] ? {1'b0, cfg_i.player_y[FRAC_BITS-1:0]}
                          : 17'd65536 - {1'b0, cfg_i.player_y[FRAC_BITS-1:0]};
  assign accx_d = mbx_q[0] ? accx_q + mcx_q : accx_q;
  assign accy_d = mby_q[0] ? accy_q + mcy_q : accy_q;

  // perpendicular distance numerator for the side crossed last
  always_comb begin
    if (!side_q) begin
      num = signed'({2'b0, mx_q[5:0], 16'd0}) - signed'({2'b0, cfg_i.player_x})
            + (rx_q[33] ? 24'sd65536 : 24'sd0);
      r_sel = rx_q;
    end else begin
      num = signed'({2'b0, my_q[5:0], 16'd0}) - signed'({2'b0, cfg_i.player_y})
            + (ry_q[33] ? 24'sd65536 : 24'sd0);
      r_sel = ry_q;
    end
    num_abs = num[23] ? 24'(-num) : 24'(num);
    r_abs   = r_sel[33] ? 34'(-r_sel) : 34'(r_sel);
  end

  assign out_x = (mx_q[7:MAP_BITS] != '0);
  assign out_y = (my_q[7:MAP_BITS] != '0);

  // drive the shared divider
  always_comb begin
    div_req_o = '{start: 1'b0, num: '0, den: '0};
    case (state_q)
      S_CAM: begin
        div_req_o.start = 1'b1;
        div_req_o.num   = DIV_NW'({item_q.column, 1'b0, 16'd0});
        div_req_o.den   = DIV_DW'(width);
      end
      S_DX: begin
        div_req_o.start = (rx_q != '0);
        div_req_o.num   = DIV_NW'(64'h1_0000_0000);
        div_req_o.den   = rx_q[33] ? 34'(-rx_q) : 34'(rx_q);
      end
      S_DY: begin
        div_req_o.start = (ry_q != '0);
        div_req_o.num   = DIV_NW'(64'h1_0000_0000);
        div_req_o.den   = ry_q[33] ? 34'(-ry_q) : 34'(ry_q);
      end
      S_PERP: begin
        div_req_o.start = (r_sel != '0) && (num != '0) && (num[23] == r_sel[33]);
        div_req_o.num   = DIV_NW'({num_abs, 16'd0});
        div_req_o.den   = r_abs;
      end
      default: ;
    endcase
  end

  // map port: clearing pass or a cell write
  assign mem_we    = (state_q == S_CLEAR) || (state_q == S_WRITE);
  assign mem_waddr = (state_q == S_CLEAR) ? clr_q : {item_q.cell_x, item_q.cell_y};
  assign mem_wdata = (state_q == S_CLEAR) ? 1'b0 : item_q.cell_wall;

  always_ff @(posedge clk_i) begin
    if (mem_we) map_mem[mem_waddr] <= mem_wdata;
    rd_q <= map_mem[{mx_q[MAP_BITS-1:0], my_q[MAP_BITS-1:0]}];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + CELL_AW'(1);
          if (clr_q == CELL_AW'(MAP_CELLS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (item_valid_i) begin
            item_q  <= item_i;
            state_q <= (item_i.func == FUNC_WRITE) ? S_WRITE : S_CAM;
          end
        end
        S_WRITE: begin
          valid_q  <= 1'b1;
          perp_q   <= '0;
          side_o_q <= 1'b0;
          hx_q     <= '0;
          hy_q     <= '0;
          status_q <= ST_WRITE;
          state_q  <= S_IDLE;
        end
        S_CAM: state_q <= S_CAM_W;
        S_CAM_W: begin
          if (div_rsp_i.done) begin
            cam_q   <= signed'({2'b0, div_rsp_i.quot[28:0]}) - 31'sd65536;
            state_q <= S_RAY_X;
          end
        end
        S_RAY_X: begin
          rx_q    <= 34'(cfg_i.view_dir_x) + 34'(prod_ray >>> FRAC_BITS);
          state_q <= S_RAY_Y;
        end
        S_RAY_Y: begin
          ry_q    <= 34'(cfg_i.view_dir_y) + 34'(prod_ray >>> FRAC_BITS);
          state_q <= S_DX;
        end
        S_DX: begin
          if (rx_q == '0) begin
            dx_q    <= DELTA_CAP;
            state_q <= S_DY;
          end else begin
            state_q <= S_DX_W;
          end
        end
        S_DX_W: begin
          if (div_rsp_i.done) begin
            dx_q    <= div_rsp_i.quot[36:0];
            state_q <= S_DY;
          end
        end
        S_DY: begin
          if (ry_q == '0) begin
            dy_q    <= DELTA_CAP;
            state_q <= S_SINIT;
          end else begin
            state_q <= S_DY_W;
          end
        end
        S_DY_W: begin
          if (div_rsp_i.done) begin
            dy_q    <= div_rsp_i.quot[36:0];
            state_q <= S_SINIT;
          end
        end
        S_SINIT: begin
          accx_q  <= '0;
          accy_q  <= '0;
          mcx_q   <= 54'(dx_q);
          mcy_q   <= 54'(dy_q);
          mbx_q   <= fracx;
          mby_q   <= fracy;
          mcnt_q  <= '0;
          mx_q    <= signed'({2'b0, cfg_i.player_x[21:16]});
          my_q    <= signed'({2'b0, cfg_i.player_y[21:16]});
          cnt_q   <= '0;
          side_q  <= 1'b0;
          state_q <= S_SIDE;
        end
        // shift-and-add for the initial side distances
        S_SIDE: begin
          accx_q <= accx_d;
          accy_q <= accy_d;
          mcx_q  <= {mcx_q[52:0], 1'b0};
          mcy_q  <= {mcy_q[52:0], 1'b0};
          mbx_q  <= mbx_q >> 1;
          mby_q  <= mby_q >> 1;
          mcnt_q <= mcnt_q + 5'd1;
          if (mcnt_q == 5'd16) begin
            sx_q    <= 45'(accx_d[53:FRAC_BITS]);
            sy_q    <= 45'(accy_d[53:FRAC_BITS]);
            state_q <= S_STEP;
          end
        end
        // advance one cell along the nearer side
        S_STEP: begin
          cnt_q <= cnt_q + 8'd1;
          if (sx_q < sy_q) begin
            sx_q   <= sx_q + 45'(dx_q);
            mx_q   <= rx_q[33] ? mx_q - 8'sd1 : mx_q + 8'sd1;
            side_q <= 1'b0;
          end else begin
            sy_q   <= sy_q + 45'(dy_q);
            my_q   <= ry_q[33] ? my_q - 8'sd1 : my_q + 8'sd1;
            side_q <= 1'b1;
          end
          state_q <= S_CHK;
        end
        S_CHK: begin
          if (out_x || out_y) begin
            valid_q  <= 1'b1;
            perp_q   <= DIST_MAX;
            side_o_q <= 1'b0;
            hx_q     <= '0;
            hy_q     <= '0;
            status_q <= ST_EDGE;
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_TEST;
          end
        end
        S_TEST: begin
          if (rd_q) begin
            state_q <= S_PERP;
          end else if (cnt_q == 8'(LOOP_MAX)) begin
            valid_q  <= 1'b1;
            perp_q   <= DIST_MAX;
            side_o_q <= 1'b0;
            hx_q     <= '0;
            hy_q     <= '0;
            status_q <= ST_EDGE;
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_STEP;
          end
        end
        S_PERP: begin
          side_o_q <= side_q;
          hx_q     <= mx_q[5:0];
          hy_q     <= my_q[5:0];
          status_q <= ST_HIT;
          if (r_sel == '0) begin
            valid_q <= 1'b1;
            perp_q  <= DIST_MAX;
            state_q <= S_IDLE;
          end else if ((num == '0) || (num[23] != r_sel[33])) begin
            valid_q <= 1'b1;
            perp_q  <= '0;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_PERP_W;
          end
        end
        S_PERP_W: begin
          if (div_rsp_i.done) begin
            valid_q <= 1'b1;
            perp_q  <= (div_rsp_i.quot > DIV_NW'(DIST_MAX)) ? DIST_MAX
                                                            : div_rsp_i.quot[21:0];
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o = valid_q;
  assign perp_dist_o    = perp_q;
  assign hit_side_o     = side_o_q;
  assign hit_x_o        = hx_q;
  assign hit_y_o        = hy_q;
  assign status_o       = status_q;

  `GDDRC_ASSERT_NOW(a_pop_ok, clk_i, rst_ni, pop_o, item_valid_i && !clearing_o)
  `GDDRC_ASSERT_NOW(a_div_idle, clk_i, rst_ni, div_req_o.start, !div_rsp_i.busy)
  `GDDRC_ASSERT_NEXT(a_one_strobe, clk_i, rst_ni, result_valid_o, !result_valid_o)

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import gddrc_pkg::*;

  typedef struct packed {
    logic [21:0] perp_dist;
    logic        hit_side;
    logic [5:0]  hit_x;
    logic [5:0]  hit_y;
    logic [1:0]  status;
  } ray_res_t;

  // one directed word; known_res set where the outcome is obvious
  typedef struct packed {
    logic        func;
    logic [11:0] column;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic        cell_wall;
    logic        known_res;
    ray_res_t    res;
  } dir_word_t;

  localparam ray_res_t WRITE_RES = '{22'd0, 1'b0, 6'd0, 6'd0, ST_WRITE};
  localparam ray_res_t EDGE_RES  = '{DIST_MAX, 1'b0, 6'd0, 6'd0, ST_EDGE};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        func_i = 1'b0;
  logic [11:0] column_i = '0;
  logic [5:0]  cell_x_i = '0;
  logic [5:0]  cell_y_i = '0;
  logic        cell_wall_i = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [21:0] cfg_data_i = '0;
  logic        result_valid_o;
  logic [21:0] perp_dist_o;
  logic        hit_side_o;
  logic [5:0]  hit_x_o;
  logic [5:0]  hit_y_o;
  logic [1:0]  status_o;

  grid_dda_ray_caster_top dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow copy of configuration and map
  logic [21:0]        sh_px, sh_py;
  logic signed [17:0] sh_dir_x, sh_dir_y, sh_plane_x, sh_plane_y;
  logic [12:0]        sh_width;
  bit                 sh_map [MAP_CELLS];

  ray_res_t pending_rays [$];
  int n_err = 0, n_hit = 0, n_edge = 0, n_write = 0, n_phase = 0;
  bit no_gaps = 0;

  function automatic longint unsigned ray_delta(longint r);
    longint unsigned a;
    a = (r < 0) ? -r : r;
    if (a == 0) return 64'd1 << 36;
    return (64'd1 << 32) / a;
  endfunction

  function automatic logic [21:0] wall_dist(longint num, longint r);
    longint unsigned n, d, q;
    if (r == 0) return DIST_MAX;
    if (num == 0 || ((num < 0) != (r < 0))) return '0;
    n = (num < 0) ? -num : num;
    d = (r < 0) ? -r : r;
    q = (n << 16) / d;
    return (q > DIST_MAX) ? DIST_MAX : q[21:0];
  endfunction

  // march the ray through the shadow map
  function automatic ray_res_t cast_ray(logic [11:0] col);
    longint wd, cam, rx, ry, mx, my, stx, sty, num;
    longint unsigned dx, dy, sx, sy;
    int side;
    bit hit;
    ray_res_t r;
    r = '0;
    side = 0;
    hit = 0;
    wd = (sh_width == 0) ? 1 : sh_width;
    cam = ((longint'(col) * 2) << 16) / wd - 65536;
    rx = longint'(sh_dir_x) + ((longint'(sh_plane_x) * cam) >>> 16);
    ry = longint'(sh_dir_y) + ((longint'(sh_plane_y) * cam) >>> 16);
    mx = sh_px >> 16;
    my = sh_py >> 16;
    dx = ray_delta(rx);
    dy = ray_delta(ry);
    if (rx < 0) begin
      stx = -1;
      sx = ((longint'(sh_px) - mx * 65536) * dx) >> 16;
    end else begin
      stx = 1;
      sx = (((mx + 1) * 65536 - longint'(sh_px)) * dx) >> 16;
    end
    if (ry < 0) begin
      sty = -1;
      sy = ((longint'(sh_py) - my * 65536) * dy) >> 16;
    end else begin
      sty = 1;
      sy = (((my + 1) * 65536 - longint'(sh_py)) * dy) >> 16;
    end
    for (int i = 0; i < LOOP_MAX; i++) begin
      if (sx < sy) begin
        sx += dx;
        mx += stx;
        side = 0;
      end else begin
        sy += dy;
        my += sty;
        side = 1;
      end
      if (mx < 0 || mx >= MAP_SIZE || my < 0 || my >= MAP_SIZE) break;
      if (sh_map[mx * MAP_SIZE + my]) begin
        hit = 1;
        break;
      end
    end
    if (!hit) return EDGE_RES;
    if (side == 0) begin
      num = mx * 65536 - longint'(sh_px) + ((stx < 0) ? 65536 : 0);
      r.perp_dist = wall_dist(num, rx);
    end else begin
      num = my * 65536 - longint'(sh_py) + ((sty < 0) ? 65536 : 0);
      r.perp_dist = wall_dist(num, ry);
    end
    r.hit_side = side[0];
    r.hit_x = mx[5:0];
    r.hit_y = my[5:0];
    r.status = ST_HIT;
    return r;
  endfunction

  // present one word, hold it until taken, then log its expected result
  task automatic send_word(logic f, logic [11:0] col, logic [5:0] cx, logic [5:0] cy,
                           logic wl, logic known, ray_res_t kres);
    int gap;
    ray_res_t r;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    func_i <= f;
    column_i <= col;
    cell_x_i <= cx;
    cell_y_i <= cy;
    cell_wall_i <= wl;
    do @(posedge clk_i); while (busy);
    if (f == FUNC_WRITE) begin
      sh_map[cx * MAP_SIZE + cy] = wl;
      r = WRITE_RES;
    end else begin
      r = cast_ray(col);
    end
    pending_rays.push_back(known ? kres : r);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_rays.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // write one register and mirror it
  task automatic cfg_write(logic [2:0] idx, logic [21:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_PLAYER_X:    sh_px = val;
      CFG_PLAYER_Y:    sh_py = val;
      CFG_VIEW_DIR_X:  sh_dir_x = val[17:0];
      CFG_VIEW_DIR_Y:  sh_dir_y = val[17:0];
      CFG_CAM_PLANE_X: sh_plane_x = val[17:0];
      CFG_CAM_PLANE_Y: sh_plane_y = val[17:0];
      CFG_SCREEN_W:    sh_width = val[12:0];
      default: ;
    endcase
  endtask

  function automatic logic [21:0] pick_vec();
    case ($urandom_range(0, 7))
      0: return 22'h20000;
      1: return 22'h1FFFF;
      2: return 22'd0;
      3: return 22'd65536;
      4: return 22'(-65536);
      default: return 22'($urandom_range(0, 18'h3FFFF));
    endcase
  endfunction

  function automatic logic [21:0] pick_width();
    case ($urandom_range(0, 7))
      0: return 22'd0;
      1: return 22'd1;
      2: return 22'd8191;
      3: return 22'd4096;
      default: return 22'($urandom_range(1, 1024));
    endcase
  endfunction

  function automatic logic [21:0] pick_pos();
    case ($urandom_range(0, 7))
      0: return 22'd0;
      1: return DIST_MAX;
      default: return 22'($urandom_range(0, 22'h3FFFFF));
    endcase
  endfunction

  // check each strobed word against the oldest expectation
  always @(posedge clk_i) begin
    ray_res_t e;
    if (rst_ni && result_valid_o) begin
      if (pending_rays.size() == 0) begin
        $error("unexpected result word, status %0d", status_o);
        n_err++;
      end else begin
        e = pending_rays.pop_front();
        if (perp_dist_o !== e.perp_dist) begin
          $error("perp_dist exp %0d got %0d", e.perp_dist, perp_dist_o);
          n_err++;
        end
        if (hit_side_o !== e.hit_side) begin
          $error("hit_side exp %0d got %0d", e.hit_side, hit_side_o);
          n_err++;
        end
        if (hit_x_o !== e.hit_x) begin
          $error("hit_x exp %0d got %0d", e.hit_x, hit_x_o);
          n_err++;
        end
        if (hit_y_o !== e.hit_y) begin
          $error("hit_y exp %0d got %0d", e.hit_y, hit_y_o);
          n_err++;
        end
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o);
          n_err++;
        end
        case (e.status)
          ST_HIT:  n_hit++;
          ST_EDGE: n_edge++;
          default: n_write++;
        endcase
      end
    end
  end

  initial begin
    #48_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  dir_word_t dir_tab [20];

  initial begin
    int wall_pct, n_items;
    sh_px = 0;
    sh_py = 0;
    sh_dir_x = 65536;
    sh_dir_y = 0;
    sh_plane_x = 0;
    sh_plane_y = 43253;
    sh_width = 640;
    foreach (sh_map[i]) sh_map[i] = 0;

    // empty map first, then corner walls and a row of walls across x = 5
    dir_tab = '{
      '{FUNC_CAST,  12'd0,    6'd0,  6'd0,  1'b0, 1'b1, EDGE_RES},
      '{FUNC_CAST,  12'd4095, 6'd0,  6'd0,  1'b0, 1'b1, EDGE_RES},
      '{FUNC_WRITE, 12'd0,    6'd63, 6'd63, 1'b1, 1'b1, WRITE_RES},
      '{FUNC_WRITE, 12'hFFF,  6'd0,  6'd63, 1'b1, 1'b1, WRITE_RES},
      '{FUNC_WRITE, 12'd0,    6'd63, 6'd0,  1'b1, 1'b1, WRITE_RES},
      '{FUNC_WRITE, 12'd0,    6'd5,  6'd0,  1'b1, 1'b1, WRITE_RES},
      '{FUNC_WRITE, 12'd0,    6'd5,  6'd1,  1'b1, 1'b1, WRITE_RES},
      '{FUNC_WRITE, 12'd0,    6'd5,  6'd2,  1'b1, 1'b1, WRITE_RES},
      '{FUNC_CAST,  12'd320,  6'd0,  6'd0,  1'b0, 1'b0, '0},
      '{FUNC_CAST,  12'd0,    6'd0,  6'd0,  1'b0, 1'b0, '0},
      '{FUNC_CAST,  12'd639,  6'd0,  6'd0,  1'b0, 1'b0, '0},
      '{FUNC_CAST,  12'd4095, 6'd0,  6'd0,  1'b0, 1'b0, '0},
      '{FUNC_CAST,  12'd2730, 6'd0,  6'd0,  1'b0, 1'b0, '0},
      '{FUNC_WRITE, 12'd0,    6'd5,  6'd1,  1'b0, 1'b1, WRITE_RES},
      '{FUNC_CAST,  12'd330,  6'd0,  6'd0,  1'b0, 1'b0, '0},
      '{FUNC_WRITE, 12'd0,    6'd42, 6'd21, 1'b1, 1'b1, WRITE_RES},
      '{FUNC_WRITE, 12'd0,    6'd21, 6'd42, 1'b1, 1'b1, WRITE_RES},
      '{FUNC_CAST,  12'd1,    6'd0,  6'd0,  1'b0, 1'b0, '0},
      '{FUNC_CAST,  12'd2048, 6'd0,  6'd0,  1'b0, 1'b0, '0},
      '{FUNC_CAST,  12'd640,  6'd0,  6'd0,  1'b0, 1'b0, '0}
    };

    // hold reset, then wait out the map clearing pass
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (busy);

    no_gaps = 1;
    foreach (dir_tab[i])
      send_word(dir_tab[i].func, dir_tab[i].column, dir_tab[i].cell_x, dir_tab[i].cell_y,
                dir_tab[i].cell_wall, dir_tab[i].known_res, dir_tab[i].res);
    drain_results();

    // random phases: fresh settings, a burst of map edits, then mostly casts
    n_items = 0;
    while (n_items < 1780) begin
      n_phase++;
      cfg_write(CFG_PLAYER_X, pick_pos());
      cfg_write(CFG_PLAYER_Y, pick_pos());
      cfg_write(CFG_VIEW_DIR_X, pick_vec());
      cfg_write(CFG_VIEW_DIR_Y, pick_vec());
      cfg_write(CFG_CAM_PLANE_X, pick_vec());
      cfg_write(CFG_CAM_PLANE_Y, pick_vec());
      cfg_write(CFG_SCREEN_W, pick_width());
      cfg_we_i <= 1'b0;
      no_gaps = ($urandom_range(0, 3) == 0);
      wall_pct = $urandom_range(5, 60);
      for (int k = 0; k < 100; k++) begin
        if ((k < 25 && $urandom_range(0, 3) != 0) || $urandom_range(0, 9) == 0)
          send_word(FUNC_WRITE, 12'($urandom), 6'($urandom), 6'($urandom),
                    ($urandom_range(0, 99) < wall_pct), 1'b0, '0);
        else if ($urandom_range(0, 3) != 0 && sh_width != 0)
          send_word(FUNC_CAST, 12'($urandom_range(0, sh_width - 1)), 6'($urandom),
                    6'($urandom), 1'($urandom), 1'b0, '0);
        else
          send_word(FUNC_CAST, 12'($urandom), 6'($urandom), 6'($urandom),
                    1'($urandom), 1'b0, '0);
      end
      n_items += 100;
      drain_results();
    end

    repeat (600) @(posedge clk_i);
    $display("covered %0d setting phases: %0d wall hits, %0d edge exits, %0d map writes",
             n_phase, n_hit, n_edge, n_write);
    if (n_err == 0 && pending_rays.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/gddrc_pkg.sv
sv/gddrc_front.sv
sv/gddrc_div.sv
sv/gddrc_back.sv
sv/grid_dda_ray_caster_top.sv
tb/sv/tb_top.sv
